@@ src/ratchet_wire_message_deframer_defines.svh @@
// ---------------------------------------------------------------------------
// Wire message deframer: assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them away.
// ---------------------------------------------------------------------------
`ifndef RATCHET_WIRE_MESSAGE_DEFRAMER_DEFINES_SVH
`define RATCHET_WIRE_MESSAGE_DEFRAMER_DEFINES_SVH
`ifndef ASSERT_OFF
`define RWMD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RWMD_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define RWMD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RWMD_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

@@ src/rwmd_pkg.sv @@
// ---------------------------------------------------------------------------
// Wire message deframer package
// Header layout constants, region and status codes, queue and result types.
// ---------------------------------------------------------------------------
`default_nettype none

package rwmd_pkg;

  localparam int unsigned KEY_BYTES  = 32;
  localparam int unsigned MAC_BYTES  = 8;
  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam int unsigned POS_W = 8;
  localparam int unsigned OFS_W = 5;
  localparam int unsigned WORD_W = 32;

  localparam logic [POS_W-1:0] POS_MSGNUM  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_PREV    = POS_W'(4 + WORD_BYTES);
  localparam logic [POS_W-1:0] POS_RAT     = POS_W'(4 + 2 * WORD_BYTES);
  localparam logic [POS_W-1:0] POS_MAC     = POS_W'(4 + 2 * WORD_BYTES + KEY_BYTES);
  localparam logic [POS_W-1:0] POS_AFTER   = POS_W'(4 + 2 * WORD_BYTES + KEY_BYTES
                                                    + MAC_BYTES);
  localparam logic [POS_W-1:0] POS_IDKEY   = POS_W'(4 + 3 * WORD_BYTES + KEY_BYTES
                                                    + MAC_BYTES);
  localparam logic [POS_W-1:0] POS_PREKEY  = POS_W'(4 + 3 * WORD_BYTES + 2 * KEY_BYTES
                                                    + MAC_BYTES);
  localparam logic [POS_W-1:0] POS_LEN_PK  = POS_W'(4 + 3 * WORD_BYTES + 3 * KEY_BYTES
                                                    + MAC_BYTES);
  localparam logic [POS_W-1:0] HDR_END     = POS_W'(4 + 3 * WORD_BYTES + KEY_BYTES
                                                    + MAC_BYTES);
  localparam logic [POS_W-1:0] HDR_END_PK  = POS_W'(4 + 4 * WORD_BYTES + 3 * KEY_BYTES
                                                    + MAC_BYTES);

  localparam logic [7:0]       KIND_PREKEY = 8'd2;
  localparam logic [OFS_W-1:0] OFS_MAX     = '1;

  typedef enum logic [3:0] {
    REG_TYPE    = 4'd0,
    REG_CURVE   = 4'd1,
    REG_VERSION = 4'd2,
    REG_FLAGS   = 4'd3,
    REG_MSGNUM  = 4'd4,
    REG_PREV    = 4'd5,
    REG_RATCHET = 4'd6,
    REG_MAC     = 4'd7,
    REG_PKID    = 4'd8,
    REG_IDKEY   = 4'd9,
    REG_PREKEY  = 4'd10,
    REG_LENGTH  = 4'd11,
    REG_PAYLOAD = 4'd12
  } region_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CORRUPT  = 2'd1,
    ST_MISMATCH = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]       byte_value;
    logic             last;
    region_e          region;
    logic [OFS_W-1:0] offset;
    logic             hdr_done;
  } item_t;

  typedef struct packed {
    logic [7:0]        byte_value;
    region_e           region;
    logic [OFS_W-1:0]  offset;
    logic              final_result;
    status_e           status;
    logic [7:0]        kind;
    logic [WORD_W-1:0] msgnum;
    logic [WORD_W-1:0] prevcount;
    logic [WORD_W-1:0] prekey_id;
    logic [WORD_W-1:0] plen;
  } result_t;

endpackage

`default_nettype wire

@@ src/rwmd_front.sv @@
// ---------------------------------------------------------------------------
// Deframer front end
// Tracks header position and type byte, tags each byte with region/offset.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ratchet_wire_message_deframer_defines.svh"

module rwmd_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [7:0]     wire_byte_i,
  input  wire logic           end_of_message_i,
  input  wire logic           full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output rwmd_pkg::item_t     item_o
);
  import rwmd_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       kind_q, kind_d;
  logic [7:0]       kind;
  logic [POS_W-1:0] hdr_end;
  logic [POS_W-1:0] pos_inc;
  logic             in_hdr;

  function automatic logic [OFS_W-1:0] rel(input logic [POS_W-1:0] p,
                                           input logic [POS_W-1:0] base);
    logic [POS_W-1:0] diff;
    diff = p - base;
    return diff[OFS_W-1:0];
  endfunction

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    kind    = (pos_q == '0) ? wire_byte_i : kind_q;
    hdr_end = (kind == KIND_PREKEY) ? HDR_END_PK : HDR_END;
    in_hdr  = pos_q < hdr_end;
    pos_inc = pos_q + POS_W'(1);

    item_o.byte_value = wire_byte_i;
    item_o.last       = end_of_message_i;
    item_o.region     = REG_PAYLOAD;
    item_o.offset     = '0;
    item_o.hdr_done   = 1'b1;

    if (in_hdr) begin
      item_o.hdr_done = pos_inc >= hdr_end;
      if (pos_q < POS_MSGNUM) begin
        item_o.region = region_e'(pos_q[3:0]);
      end else if (pos_q < POS_PREV) begin
        item_o.region = REG_MSGNUM;
        item_o.offset = rel(pos_q, POS_MSGNUM);
      end else if (pos_q < POS_RAT) begin
        item_o.region = REG_PREV;
        item_o.offset = rel(pos_q, POS_PREV);
      end else if (pos_q < POS_MAC) begin
        item_o.region = REG_RATCHET;
        item_o.offset = rel(pos_q, POS_RAT);
      end else if (pos_q < POS_AFTER) begin
        item_o.region = REG_MAC;
        item_o.offset = rel(pos_q, POS_MAC);
      end else if (kind != KIND_PREKEY) begin
        item_o.region = REG_LENGTH;
        item_o.offset = rel(pos_q, POS_AFTER);
      end else if (pos_q < POS_IDKEY) begin
        item_o.region = REG_PKID;
        item_o.offset = rel(pos_q, POS_AFTER);
      end else if (pos_q < POS_PREKEY) begin
        item_o.region = REG_IDKEY;
        item_o.offset = rel(pos_q, POS_IDKEY);
      end else if (pos_q < POS_LEN_PK) begin
        item_o.region = REG_PREKEY;
        item_o.offset = rel(pos_q, POS_PREKEY);
      end else begin
        item_o.region = REG_LENGTH;
        item_o.offset = rel(pos_q, POS_LEN_PK);
      end
    end
  end

  always_comb begin
    pos_d  = pos_q;
    kind_d = kind_q;
    if (push_o) begin
      if (end_of_message_i) begin
        pos_d  = '0;
        kind_d = '0;
      end else if (in_hdr) begin
        pos_d = pos_inc;
        if (pos_q == '0) begin
          kind_d = wire_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kind_q <= '0;
    end else begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
    end
  end

  `RWMD_ASSERT(a_pos_bound, clk_i, rst_ni, pos_q <= HDR_END_PK, "header position overran")
  `RWMD_ASSERT(a_pos_plain, clk_i, rst_ni, (pos_q > HDR_END) |-> (kind_q == KIND_PREKEY), "long header without pre-key type")

endmodule

`default_nettype wire

@@ src/rwmd_fifo.sv @@
// ---------------------------------------------------------------------------
// Deframer queue
// Small first-word-fall-through queue between front end and back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ratchet_wire_message_deframer_defines.svh"

module rwmd_fifo #(
  parameter int unsigned DEPTH = rwmd_pkg::FIFO_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rwmd_pkg::item_t wdata_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output rwmd_pkg::item_t      rdata_o
);
  import rwmd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `RWMD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(DEPTH), "queue count overran")
  `RWMD_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o && !do_pop, "push into full queue")

endmodule

`default_nettype wire

@@ src/rwmd_back.sv @@
// ---------------------------------------------------------------------------
// Deframer back end
// Decodes header words, counts payload, closes message, holds result word.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ratchet_wire_message_deframer_defines.svh"

module rwmd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire rwmd_pkg::item_t item_i,
  output logic                 pop_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output rwmd_pkg::result_t    res_o
);
  import rwmd_pkg::*;

  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;
  logic [7:0]        kind_q, kind_d;
  logic [WORD_W-1:0] msg_q, msg_d;
  logic [WORD_W-1:0] prev_q, prev_d;
  logic [WORD_W-1:0] pkid_q, pkid_d;
  logic [WORD_W-1:0] len_q, len_d;
  logic [WORD_W-1:0] cnt_q, cnt_d;
  status_e           status;

  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    kind_d      = kind_q;
    msg_d       = msg_q;
    prev_d      = prev_q;
    pkid_d      = pkid_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    status      = ST_OK;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (pop_o) begin
      out_valid_d      = 1'b1;
      res_d.byte_value = item_i.byte_value;
      res_d.region     = item_i.region;
      res_d.offset     = item_i.offset;

      case (item_i.region)
        REG_TYPE:   kind_d = item_i.byte_value;
        REG_MSGNUM: msg_d  = {msg_q[WORD_W-9:0], item_i.byte_value};
        REG_PREV:   prev_d = {prev_q[WORD_W-9:0], item_i.byte_value};
        REG_PKID:   pkid_d = {pkid_q[WORD_W-9:0], item_i.byte_value};
        REG_LENGTH: len_d  = {len_q[WORD_W-9:0], item_i.byte_value};
        REG_PAYLOAD: begin
          res_d.offset = (cnt_q[WORD_W-1:OFS_W] != '0) ? OFS_MAX : cnt_q[OFS_W-1:0];
          if (!(&cnt_q)) begin
            cnt_d = cnt_q + WORD_W'(1);
          end
        end
        default: ;
      endcase

      if (item_i.last) begin
        if (!item_i.hdr_done || (cnt_d < len_d)) begin
          status = ST_CORRUPT;
        end else if (cnt_d > len_d) begin
          status = ST_MISMATCH;
        end
      end

      res_d.final_result = item_i.last;
      res_d.status       = status;
      res_d.kind         = kind_d;
      res_d.msgnum       = msg_d;
      res_d.prevcount    = prev_d;
      res_d.prekey_id    = pkid_d;
      res_d.plen         = (status == ST_CORRUPT) ? '0 : len_d;

      if (item_i.last) begin
        kind_d = '0;
        msg_d  = '0;
        prev_d = '0;
        pkid_d = '0;
        len_d  = '0;
        cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kind_q      <= '0;
      msg_q       <= '0;
      prev_q      <= '0;
      pkid_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      msg_q       <= msg_d;
      prev_q      <= prev_d;
      pkid_q      <= pkid_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
    end
  end

  `RWMD_ASSERT(a_status_final, clk_i, rst_ni, (out_valid_q && !res_q.final_result) |-> (res_q.status == ST_OK), "status outside final word")
  `RWMD_ASSERT(a_corrupt_len, clk_i, rst_ni, (out_valid_q && res_q.status == ST_CORRUPT) |-> (res_q.plen == '0), "corrupt close with length")
  `RWMD_ASSERT(a_close_clear, clk_i, rst_ni, (pop_o && item_i.last) |=> (cnt_q == '0 && len_q == '0), "state not cleared after close")

endmodule

`default_nettype wire

@@ src/ratchet_wire_message_deframer.sv @@
// ---------------------------------------------------------------------------
// Ratchet wire message deframer
// Tags each wire byte with header region/offset and decodes header words.
// ---------------------------------------------------------------------------
// Takes one byte per cycle unless the queue is full and gives one result word
// per byte when the output is free. The front end classifies bytes by header
// position, a FIFO_DEPTH-entry queue decouples it from the back end, which
// decodes the big-endian words, counts payload and registers the result.
// in_ready_o drops only when the queue is full under output backpressure.
`default_nettype none

module ratchet_wire_message_deframer #(
  parameter int unsigned FIFO_DEPTH = rwmd_pkg::FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  wire_byte_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       byte_value_o,
  output logic [3:0]       region_o,
  output logic [4:0]       region_offset_o,
  output logic             final_result_o,
  output logic [1:0]       parse_status_o,
  output logic [7:0]       message_kind_o,
  output logic [31:0]      message_number_o,
  output logic [31:0]      previous_chain_count_o,
  output logic [31:0]      prekey_id_o,
  output logic [31:0]      payload_length_o
);
  import rwmd_pkg::*;

  item_t   push_item, pop_item;
  result_t res;
  logic    push, pop, full, q_valid;

  rwmd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .wire_byte_i      (wire_byte_i),
    .end_of_message_i (end_of_message_i),
    .full_i           (full),
    .in_ready_o       (in_ready_o),
    .push_o           (push),
    .item_o           (push_item)
  );

  rwmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .rdata_o (pop_item)
  );

  rwmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign byte_value_o           = res.byte_value;
  assign region_o               = res.region;
  assign region_offset_o        = res.offset;
  assign final_result_o         = res.final_result;
  assign parse_status_o         = res.status;
  assign message_kind_o         = res.kind;
  assign message_number_o       = res.msgnum;
  assign previous_chain_count_o = res.prevcount;
  assign prekey_id_o            = res.prekey_id;
  assign payload_length_o       = res.plen;

endmodule

`default_nettype wire
